// ----- hdl/tca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold cellular automaton package
// Grid geometry, field widths, item kinds and register map shared by the
// channel interfaces and the grid engine.
// ----------------------------------------------------------------------------
package tca_pkg;

  // Grid geometry.
  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 128;
  localparam int ROW_AW      = $clog2(GRID_HEIGHT);
  localparam int COL_AW      = $clog2(GRID_WIDTH);
  localparam int GEN_CW      = $clog2(GRID_HEIGHT + 2);

  // Payload field widths.
  localparam int KIND_W   = 2;
  localparam int COLUMN_W = 7;
  localparam int ROW_W    = 7;
  localparam int THR_W    = 4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GEN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // Configuration register map.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_BIRTH_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] BIRTH_THRESHOLD_RESET = 4'd4;

  typedef logic [GRID_WIDTH-1:0] grid_row_t;

endpackage

// ----- hdl/tca_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one grid command per beat.
// ----------------------------------------------------------------------------
interface tca_in_if;
  logic                        valid;
  logic                        ready;
  logic [tca_pkg::KIND_W-1:0]   kind;
  logic [tca_pkg::COLUMN_W-1:0] column;
  logic [tca_pkg::ROW_W-1:0]    row;
  logic                        write_value;

  modport source (output valid, kind, column, row, write_value, input ready);
  modport sink   (input valid, kind, column, row, write_value, output ready);
endinterface

// ----- hdl/tca_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one completion beat per grid command.
// ----------------------------------------------------------------------------
interface tca_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic done_res;

  modport source (output valid, cell_value, done_res, input ready);
  modport sink   (input valid, cell_value, done_res, output ready);
endinterface

// ----- hdl/threshold_cellular_automaton_grid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold cellular automaton grid
// Two row-wide banks of one-bit cells with a row-streaming generation engine.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one command per beat: write a cell, compute the next
//   generation, or read a cell. out_chan returns exactly one beat per
//   command: cell_value holds the cell for a read and zero otherwise, and
//   done_res is always one. The cfg_ APB port holds birth_threshold.
//   Each bank is a memory of 128 rows of 128 cells, one row read and one
//   row written per cycle, with a registered read.
//   Operation: a write or an unused kind completes from the output register;
//   a read waits for the registered memory read in ST_READ; a generation
//   streams one source row per cycle through a three-row window and writes
//   one destination row per cycle, then swaps banks.
//   One command is in flight at a time.
//   Reset: a clearing pass zeroes both banks row by row; no command is
//   accepted during it, configuration writes still are.
//   Stall: the result sits in an output register; a new command is taken
//   only when that register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module threshold_cellular_automaton_grid (
  input  logic                         clk,
  input  logic                         rst_n,
  tca_in_if.sink                       in_chan,
  tca_out_if.source                    out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tca_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tca_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tca_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_GEN   = 4'b1000
  } state_t;

  // Next-generation row: interior cells follow the threshold rule,
  // the first and last column copy the middle row.
  function automatic tca_pkg::grid_row_t gen_row(
    input tca_pkg::grid_row_t          up,
    input tca_pkg::grid_row_t          mid,
    input tca_pkg::grid_row_t          dn,
    input logic [tca_pkg::THR_W-1:0]   thr
  );
    tca_pkg::grid_row_t res;
    logic [3:0]         n;
    res = mid;
    for (int x = 1; x < tca_pkg::GRID_WIDTH - 1; x++) begin
      n = 4'(up[x-1]) + 4'(up[x]) + 4'(up[x+1]) + 4'(mid[x-1]) + 4'(mid[x+1])
        + 4'(dn[x-1]) + 4'(dn[x]) + 4'(dn[x+1]);
      res[x] = (n >= thr);
    end
    return res;
  endfunction

  // Cell memories.
  tca_pkg::grid_row_t bank_a_mem [tca_pkg::GRID_HEIGHT];
  tca_pkg::grid_row_t bank_b_mem [tca_pkg::GRID_HEIGHT];

  state_t                        st_r, st_nxt;
  logic                          active_r, active_nxt;
  logic [tca_pkg::THR_W-1:0]     thr_r;
  logic [tca_pkg::ROW_AW-1:0]    clr_row_r, clr_row_nxt;
  logic [tca_pkg::GEN_CW-1:0]    gen_cnt_r, gen_cnt_nxt;
  tca_pkg::grid_row_t            up_r, up_nxt;
  tca_pkg::grid_row_t            mid_r, mid_nxt;
  tca_pkg::grid_row_t            rdata_a_r, rdata_b_r;
  logic [tca_pkg::COL_AW-1:0]    rd_col_r, rd_col_nxt;
  logic                          rd_on_r, rd_on_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_cell_r, out_cell_nxt;

  logic                          in_ready;
  logic                          acc;
  logic                          on_grid;
  logic [tca_pkg::COL_AW-1:0]    col_idx;
  logic [tca_pkg::ROW_AW-1:0]    rd_row;
  tca_pkg::grid_row_t            src_row;
  logic                          wr_clr, wr_cur, wr_dst;
  logic                          wr_en_a, wr_en_b;
  logic [tca_pkg::ROW_AW-1:0]    wr_row;
  tca_pkg::grid_row_t            wr_data, wr_mask;
  logic                          cfg_wr;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[tca_pkg::CFG_AW-1] == tca_pkg::REG_BIRTH_THRESHOLD) ?
                      tca_pkg::CFG_DW'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tca_pkg::BIRTH_THRESHOLD_RESET;
    end else if (cfg_wr &&
                 cfg_paddr[tca_pkg::CFG_AW-1] == tca_pkg::REG_BIRTH_THRESHOLD) begin
      thr_r <= cfg_pwdata[tca_pkg::THR_W-1:0];
    end
  end

  // Handshake and address decode.
  assign in_ready      = (st_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = in_ready;
  assign acc           = in_chan.valid && in_ready;
  assign on_grid       = (32'(in_chan.column) < tca_pkg::GRID_WIDTH) &&
                         (32'(in_chan.row) < tca_pkg::GRID_HEIGHT);
  assign col_idx       = tca_pkg::COL_AW'(in_chan.column);
  assign src_row       = active_r ? rdata_b_r : rdata_a_r;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_value = out_cell_r;
  assign out_chan.done_res   = 1'b1;

  // Sequencer: read address, write port and next state.
  always_comb begin
    st_nxt        = st_r;
    active_nxt    = active_r;
    clr_row_nxt   = clr_row_r;
    gen_cnt_nxt   = gen_cnt_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    rd_col_nxt    = rd_col_r;
    rd_on_nxt     = rd_on_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_cell_nxt  = out_cell_r;
    rd_row        = tca_pkg::ROW_AW'(in_chan.row);
    wr_clr        = 1'b0;
    wr_cur        = 1'b0;
    wr_dst        = 1'b0;
    wr_row        = tca_pkg::ROW_AW'(in_chan.row);
    wr_data       = {tca_pkg::GRID_WIDTH{in_chan.write_value}};
    wr_mask       = tca_pkg::GRID_WIDTH'(1) << col_idx;

    unique case (st_r)
      ST_CLEAR: begin
        // Zero one row of both banks per cycle.
        wr_clr  = 1'b1;
        wr_row  = clr_row_r;
        wr_data = '0;
        wr_mask = '1;
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == tca_pkg::ROW_AW'(tca_pkg::GRID_HEIGHT - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (in_chan.kind)
            tca_pkg::KIND_WRITE: begin
              wr_cur        = on_grid;
              out_valid_nxt = 1'b1;
              out_cell_nxt  = 1'b0;
            end
            tca_pkg::KIND_GEN: begin
              gen_cnt_nxt = '0;
              st_nxt      = ST_GEN;
            end
            tca_pkg::KIND_READ: begin
              rd_col_nxt = col_idx;
              rd_on_nxt  = on_grid;
              st_nxt     = ST_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_cell_nxt  = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        // Row data is back from the current bank.
        out_valid_nxt = 1'b1;
        out_cell_nxt  = rd_on_r & src_row[rd_col_r];
        st_nxt        = ST_IDLE;
      end
      ST_GEN: begin
        // Issue a source row read from the counter; reads past the last row go unused.
        rd_row      = tca_pkg::ROW_AW'(gen_cnt_r);
        gen_cnt_nxt = gen_cnt_r + 1'b1;
        wr_mask     = '1;
        wr_row      = tca_pkg::ROW_AW'(gen_cnt_r - tca_pkg::GEN_CW'(2));
        wr_data     = gen_row(up_r, mid_r, src_row, thr_r);
        if (gen_cnt_r == tca_pkg::GEN_CW'(tca_pkg::GRID_HEIGHT + 1)) begin
          // Bottom border row is copied from the window, then swap banks.
          wr_dst        = 1'b1;
          wr_row        = tca_pkg::ROW_AW'(tca_pkg::GRID_HEIGHT - 1);
          wr_data       = mid_r;
          active_nxt    = !active_r;
          out_valid_nxt = 1'b1;
          out_cell_nxt  = 1'b0;
          st_nxt        = ST_IDLE;
        end else if (gen_cnt_r != '0) begin
          // A source row has arrived: slide the window.
          up_nxt  = mid_r;
          mid_nxt = src_row;
          if (gen_cnt_r == tca_pkg::GEN_CW'(1)) begin
            // Top border row is copied straight across.
            wr_dst  = 1'b1;
            wr_row  = '0;
            wr_data = src_row;
          end else if (gen_cnt_r != tca_pkg::GEN_CW'(2)) begin
            wr_dst = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign wr_en_a = wr_clr || (wr_cur && !active_r) || (wr_dst && active_r);
  assign wr_en_b = wr_clr || (wr_cur && active_r) || (wr_dst && !active_r);

  // Bank memories: one masked row write and one registered row read.
  always_ff @(posedge clk) begin
    for (int i = 0; i < tca_pkg::GRID_WIDTH; i++) begin
      if (wr_en_a && wr_mask[i]) begin
        bank_a_mem[wr_row][i] <= wr_data[i];
      end
      if (wr_en_b && wr_mask[i]) begin
        bank_b_mem[wr_row][i] <= wr_data[i];
      end
    end
    rdata_a_r <= bank_a_mem[rd_row];
    rdata_b_r <= bank_b_mem[rd_row];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      active_r    <= 1'b0;
      clr_row_r   <= '0;
      gen_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      active_r    <= active_nxt;
      clr_row_r   <= clr_row_nxt;
      gen_cnt_r   <= gen_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    rd_col_r   <= rd_col_nxt;
    rd_on_r    <= rd_on_nxt;
    out_cell_r <= out_cell_nxt;
  end

endmodule

// ----- verif/tb_threshold_cellular_automaton_grid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the threshold cellular automaton grid
// Sends write, generation, read and unused commands through the command
// channel with random idling on both channels. Between phases it changes the
// birth threshold over the APB port. Every result beat is checked against a
// cell-level model of both banks kept in step with the block, or a typed-in cell.
// ----------------------------------------------------------------------------
module tb_threshold_cellular_automaton_grid;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_COUNT  = 9;
  localparam int PHASE_ITEMS  = 125;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = tca_pkg::GRID_HEIGHT + 16;

  // Register addresses: the threshold register, and one address with no register.
  localparam logic [tca_pkg::CFG_AW-1:0] THRESHOLD_ADDR =
    {tca_pkg::REG_BIRTH_THRESHOLD, 2'b00};
  localparam logic [tca_pkg::CFG_AW-1:0] UNMAPPED_ADDR  = 3'd4;

  // Threshold for each phase, with the extremes among them; the last phase is random.
  localparam logic [tca_pkg::THR_W-1:0] PHASE_THRESHOLD [0:7] = '{
    4'd0, 4'd8, 4'd15, 4'd1, 4'd3, 4'd9, 4'd2, 4'd5
  };

  typedef struct packed {
    logic cell_value;
    logic done_res;
  } grid_result_t;

  typedef struct packed {
    logic [tca_pkg::KIND_W-1:0]   kind;
    logic [tca_pkg::COLUMN_W-1:0] column;
    logic [tca_pkg::ROW_W-1:0]    row;
    logic                         write_value;
    logic                         known;
    logic                         known_cell;
  } grid_cmd_t;

  // Directed commands. Rows with known set carry an expected cell typed in;
  // the others are checked against the cell model.
  localparam grid_cmd_t DIRECTED [0:24] = '{
    '{tca_pkg::KIND_READ,  7'd0,   7'd0,   1'b0, 1'b1, 1'b0},  // cleared after reset
    '{tca_pkg::KIND_READ,  7'd127, 7'd127, 1'b0, 1'b1, 1'b0},
    '{tca_pkg::KIND_READ,  7'd85,  7'd42,  1'b0, 1'b1, 1'b0},
    '{tca_pkg::KIND_NONE,  7'd127, 7'd127, 1'b1, 1'b1, 1'b0},  // unused kind changes nothing
    '{tca_pkg::KIND_WRITE, 7'd127, 7'd127, 1'b1, 1'b1, 1'b0},
    '{tca_pkg::KIND_READ,  7'd127, 7'd127, 1'b0, 1'b1, 1'b1},
    '{tca_pkg::KIND_WRITE, 7'd0,   7'd0,   1'b1, 1'b1, 1'b0},
    '{tca_pkg::KIND_WRITE, 7'd127, 7'd0,   1'b1, 1'b1, 1'b0},
    '{tca_pkg::KIND_WRITE, 7'd10,  7'd10,  1'b1, 1'b0, 1'b0},
    '{tca_pkg::KIND_WRITE, 7'd11,  7'd10,  1'b1, 1'b0, 1'b0},
    '{tca_pkg::KIND_WRITE, 7'd10,  7'd11,  1'b1, 1'b0, 1'b0},
    '{tca_pkg::KIND_WRITE, 7'd11,  7'd11,  1'b1, 1'b0, 1'b0},
    '{tca_pkg::KIND_WRITE, 7'd12,  7'd12,  1'b1, 1'b0, 1'b0},
    '{tca_pkg::KIND_NONE,  7'd10,  7'd10,  1'b0, 1'b1, 1'b0},
    '{tca_pkg::KIND_READ,  7'd10,  7'd10,  1'b0, 1'b1, 1'b1},
    '{tca_pkg::KIND_GEN,   7'd127, 7'd0,   1'b1, 1'b1, 1'b0},
    '{tca_pkg::KIND_READ,  7'd0,   7'd0,   1'b0, 1'b1, 1'b1},  // border cells are kept
    '{tca_pkg::KIND_READ,  7'd127, 7'd0,   1'b0, 1'b1, 1'b1},
    '{tca_pkg::KIND_READ,  7'd10,  7'd10,  1'b0, 1'b0, 1'b0},
    '{tca_pkg::KIND_READ,  7'd11,  7'd11,  1'b0, 1'b0, 1'b0},
    '{tca_pkg::KIND_READ,  7'd12,  7'd11,  1'b0, 1'b0, 1'b0},
    '{tca_pkg::KIND_WRITE, 7'd127, 7'd127, 1'b0, 1'b1, 1'b0},
    '{tca_pkg::KIND_READ,  7'd127, 7'd127, 1'b0, 1'b1, 1'b0},
    '{tca_pkg::KIND_GEN,   7'd0,   7'd127, 1'b0, 1'b1, 1'b0},
    '{tca_pkg::KIND_READ,  7'd11,  7'd11,  1'b0, 1'b0, 1'b0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [tca_pkg::CFG_AW-1:0]    cfg_paddr;
  logic [tca_pkg::CFG_DW-1:0]    cfg_pwdata;
  logic [tca_pkg::CFG_DW-1:0]    cfg_prdata;
  logic                          cfg_pready;

  tca_in_if  in_chan ();
  tca_out_if out_chan ();

  // Cell model: both banks, the current bank and the threshold.
  tca_pkg::grid_row_t            grid_cells [2][tca_pkg::GRID_HEIGHT];
  bit                            live_bank;
  logic [tca_pkg::THR_W-1:0]     thr_model;

  grid_result_t pending_results [$];
  int           fail_count;
  int           items_sent;
  int           cycle_count;
  int           hold_request;
  bit           source_steady;
  bit           sink_steady;

  threshold_cellular_automaton_grid u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Run limit, counted in clock cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Origin of a square patch, often against an edge of the grid.
  function automatic int pick_origin(int extent, int span);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return extent - span;
      default: return $urandom_range(0, extent - span);
    endcase
  endfunction

  // One generation: interior cells count their eight neighbours, borders copy.
  function automatic void advance_generation();
    int  x, y, dx, dy, live;
    bit  next_bank;
    next_bank = ~live_bank;
    for (y = 0; y < tca_pkg::GRID_HEIGHT; y++) begin
      for (x = 0; x < tca_pkg::GRID_WIDTH; x++) begin
        if (x == 0 || y == 0 || x == tca_pkg::GRID_WIDTH - 1 ||
            y == tca_pkg::GRID_HEIGHT - 1) begin
          grid_cells[next_bank][y][x] = grid_cells[live_bank][y][x];
        end else begin
          live = 0;
          for (dy = -1; dy <= 1; dy++)
            for (dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0) live += grid_cells[live_bank][y + dy][x + dx];
          grid_cells[next_bank][y][x] = (live >= thr_model);
        end
      end
    end
    live_bank = next_bank;
  endfunction

  // Applies one command to the cell model and returns the cell it reads.
  function automatic logic apply_cmd(logic [tca_pkg::KIND_W-1:0] kind, int col, int row,
                                     logic wv);
    logic read_bit;
    bit   on_grid;
    read_bit = 1'b0;
    on_grid  = (col < tca_pkg::GRID_WIDTH) && (row < tca_pkg::GRID_HEIGHT);
    case (kind)
      tca_pkg::KIND_WRITE: if (on_grid) grid_cells[live_bank][row][col] = wv;
      tca_pkg::KIND_GEN:   advance_generation();
      tca_pkg::KIND_READ:  if (on_grid) read_bit = grid_cells[live_bank][row][col];
      default:             ;
    endcase
    return read_bit;
  endfunction

  // Offers one command beat, waits for it to be taken and records its result.
  task automatic send_cmd(input logic [tca_pkg::KIND_W-1:0] kind, input int col,
                          input int row, input logic wv, input bit known = 1'b0,
                          input logic known_cell = 1'b0);
    grid_result_t want;
    int           gap;
    in_chan.valid       <= 1'b1;
    in_chan.kind        <= kind;
    in_chan.column      <= tca_pkg::COLUMN_W'(col);
    in_chan.row         <= tca_pkg::ROW_W'(row);
    in_chan.write_value <= wv;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    want.cell_value = apply_cmd(kind, col, row, wv);
    if (known) want.cell_value = known_cell;
    want.done_res = 1'b1;
    pending_results.push_back(want);
    items_sent++;
    gap = pick_gap(source_steady);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle until pready, then idle.
  task automatic cfg_write(input logic [tca_pkg::CFG_AW-1:0] addr,
                           input logic [tca_pkg::CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if ((addr >> 2) == tca_pkg::REG_BIRTH_THRESHOLD) thr_model = data[tca_pkg::THR_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // APB read of the threshold register, compared with the model.
  task automatic cfg_check_threshold();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= THRESHOLD_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== tca_pkg::CFG_DW'(thr_model)) begin
      $display("%0t: birth_threshold readback mismatch, expected %0d, got %0d",
               $time, thr_model, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // A patch of random cells, then generations with reads inside the patch.
  task automatic run_patch();
    int span, r0, c0, density, count, i, gens;
    span    = $urandom_range(3, 10);
    r0      = pick_origin(tca_pkg::GRID_HEIGHT, span);
    c0      = pick_origin(tca_pkg::GRID_WIDTH, span);
    density = $urandom_range(15, 85);
    count   = $urandom_range(span, 3 * span);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_cmd(tca_pkg::KIND_READ, c0 + $urandom_range(0, span - 1),
                 r0 + $urandom_range(0, span - 1), 1'($urandom_range(0, 1)));
      else
        send_cmd(tca_pkg::KIND_WRITE, c0 + $urandom_range(0, span - 1),
                 r0 + $urandom_range(0, span - 1), $urandom_range(0, 99) < density);
    end
    for (gens = $urandom_range(1, 3); gens > 0; gens--) begin
      send_cmd(tca_pkg::KIND_GEN, $urandom_range(0, 127), $urandom_range(0, 127),
               1'($urandom_range(0, 1)));
      for (i = $urandom_range(2, 6); i > 0; i--)
        send_cmd(tca_pkg::KIND_READ, c0 + $urandom_range(0, span - 1),
                 r0 + $urandom_range(0, span - 1), 1'($urandom_range(0, 1)));
    end
  endtask

  // Commands of any kind at any position.
  task automatic run_noise(input int count);
    int i;
    for (i = 0; i < count; i++)
      send_cmd(tca_pkg::KIND_W'($urandom_range(0, 3)), $urandom_range(0, 127),
               $urandom_range(0, 127), 1'($urandom_range(0, 1)));
  endtask

  // Result sink: random stalls, plus a long hold-off when one is requested.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(sink_steady);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Result check: every beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    grid_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, cell_value %0b, done_res %0b",
                 $time, out_chan.cell_value, out_chan.done_res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.cell_value !== want.cell_value) begin
          $display("%0t: cell_value mismatch, expected %0b, got %0b",
                   $time, want.cell_value, out_chan.cell_value);
          fail_count++;
        end
        if (out_chan.done_res !== want.done_res) begin
          $display("%0t: done_res mismatch, expected %0b, got %0b",
                   $time, want.done_res, out_chan.done_res);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int                           p, i, phase_start;
    logic [tca_pkg::CFG_DW-1:0]   wdata;

    // Known values on every input, the model in its reset state.
    fail_count    = 0;
    items_sent    = 0;
    cycle_count   = 0;
    hold_request  = 0;
    source_steady = 1'b0;
    sink_steady   = 1'b0;
    live_bank     = 1'b0;
    thr_model     = tca_pkg::BIRTH_THRESHOLD_RESET;
    for (i = 0; i < tca_pkg::GRID_HEIGHT; i++) begin
      grid_cells[0][i] = '0;
      grid_cells[1][i] = '0;
    end
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.kind        <= tca_pkg::KIND_WRITE;
    in_chan.column      <= '0;
    in_chan.row         <= '0;
    in_chan.write_value <= 1'b0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands at the reset threshold.
    for (i = 0; i < $size(DIRECTED); i++)
      send_cmd(DIRECTED[i].kind, DIRECTED[i].column, DIRECTED[i].row,
               DIRECTED[i].write_value, DIRECTED[i].known, DIRECTED[i].known_cell);

    // Random phases, each with its own threshold written while the block is idle.
    for (p = 0; p < PHASE_COUNT; p++) begin
      if (in_chan.valid === 1'b1) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
      wait_results_drained();
      wdata = $urandom();
      wdata[tca_pkg::THR_W-1:0] = (p < 8) ? PHASE_THRESHOLD[p] :
                                  tca_pkg::THR_W'($urandom_range(0, 15));
      cfg_write(THRESHOLD_ADDR, wdata);
      // A write with no register behind it must leave the threshold alone.
      if (p == 3) cfg_write(UNMAPPED_ADDR, $urandom());
      cfg_check_threshold();

      source_steady = (p % 3 == 1);
      sink_steady   = (p % 4 == 2);
      phase_start   = items_sent;

      // First phase: the sink holds off while commands keep coming.
      if (p == 0) begin
        source_steady = 1'b1;
        hold_request  = LONG_HOLD;
        run_noise(12);
        source_steady = 1'b0;
      end

      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) run_noise($urandom_range(1, 6));
        else run_patch();
        // In one phase, near its midpoint, the source pauses until every result is back.
        if (p == 2 && items_sent - phase_start >= PHASE_ITEMS / 2 &&
            items_sent - phase_start < PHASE_ITEMS / 2 + 30) begin
          if (in_chan.valid === 1'b1) begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
          end
          wait_results_drained();
        end
      end
    end

    if (in_chan.valid === 1'b1) in_chan.valid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
